// File: rtl/core/lpp_pkg.sv
package lpp_pkg;

    // Default frame count and reset pool size
    localparam int NUM_FRAMES_DEF  = 16;
    localparam int POOL_SIZE_RESET = 16;

    // Operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_NO_FRAME      = 2'd1;
    localparam logic [1:0] ST_CLOSE_BLOCKED = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  tbl_id;
        logic [31:0] page_number;
        logic [3:0]  frame_index;
        logic        set_dirty;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  frame;
        logic        writeback_valid;
        logic [7:0]  writeback_table;
        logic [31:0] writeback_page;
        logic        last;
    } t_out_item;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        K_REQ,
        K_REL,
        K_CLOSE,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tbl_id;
        logic [31:0] page_number;
        logic [3:0]  frame_index;
        logic        set_dirty;
    } t_cmd;

endpackage

// File: rtl/core/lpp_front.sv
module lpp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  lpp_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    output lpp_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_take
);
    import lpp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    t_cmd       w_cls;
    logic       w_wr;
    logic       w_rd;

    // Classify the operation code
    always_comb begin
        w_cls.tbl_id      = i_item.tbl_id;
        w_cls.page_number = i_item.page_number;
        w_cls.frame_index = i_item.frame_index;
        w_cls.set_dirty   = i_item.set_dirty;
        unique case (i_item.operation)
            OP_REQUEST: w_cls.kind = K_REQ;
            OP_RELEASE: w_cls.kind = K_REL;
            OP_CLOSE:   w_cls.kind = K_CLOSE;
            default:    w_cls.kind = K_BAD;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    // Two-entry item queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_mem[r_wptr] <= w_cls;
                r_wptr        <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

// File: rtl/core/lpp_outq.sv
module lpp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  lpp_pkg::t_out_item i_res,
    output logic               o_full,
    output logic               empty,
    input  logic               pop,
    output lpp_pkg::t_out_item o_result
);
    import lpp_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full   = (r_count == 2'd2);
    assign empty    = (r_count == 2'd0);
    assign o_result = r_mem[r_rptr];
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = pop && !empty;

    // Two-entry result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_mem[r_wptr] <= i_res;
                r_wptr        <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

// File: rtl/core/lpp_back.sv
module lpp_back #(
    parameter int NUM_FRAMES = lpp_pkg::NUM_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_cmd_valid,
    input  lpp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_emit,
    output lpp_pkg::t_out_item o_res,
    input  logic               i_out_full
);
    import lpp_pkg::*;

    localparam int LW = $clog2(NUM_FRAMES + 1);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam logic [LW-1:0] NIL = LW'(NUM_FRAMES);
    localparam logic [LW-1:0] POOL_RST =
        LW'(POOL_SIZE_RESET < NUM_FRAMES ? POOL_SIZE_RESET : NUM_FRAMES);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_MISS, S_VICT, S_MOVE, S_CWALK
    } t_state;

    typedef enum logic [1:0] { M_HIT, M_LOAD, M_REL } t_move;

    // Frame state
    logic [7:0]    r_tab    [NUM_FRAMES];
    logic [31:0]   r_page   [NUM_FRAMES];
    logic          r_dirty  [NUM_FRAMES];
    logic [7:0]    r_pins   [NUM_FRAMES];
    logic [LW-1:0] r_older  [NUM_FRAMES];
    logic [LW-1:0] r_newer  [NUM_FRAMES];
    logic          r_res    [NUM_FRAMES];
    logic [FW-1:0] r_fstk   [NUM_FRAMES];
    logic [LW-1:0] r_newest;
    logic [LW-1:0] r_oldest;
    logic [LW-1:0] r_used;
    logic [LW-1:0] r_ftop;
    logic [LW-1:0] r_pool;

    // Sequencer
    t_state        r_state;
    t_move         r_move;
    t_cmd          r_cmd;
    logic [LW-1:0] r_cur;
    logic [FW-1:0] r_f;
    logic          r_inlist;
    logic          r_wbv;
    logic [7:0]    r_wbt;
    logic [31:0]   r_wbp;
    logic          r_emit;
    t_out_item     r_out;

    logic [FW-1:0] w_rd;
    logic [7:0]    w_tab;
    logic [31:0]   w_page;
    logic          w_dirty;
    logic [7:0]    w_pins;
    logic [LW-1:0] w_older;
    logic [LW-1:0] w_newer;
    logic          w_cur_nil;
    logic          w_can_emit;
    logic          w_rel_ok;
    logic [LW-1:0] w_f_l;
    logic [LW-1:0] w_cfg_v;

    // One shared read address per cycle
    assign w_rd       = (r_state == S_MOVE) ? r_f : FW'(r_cur);
    assign w_tab      = r_tab[w_rd];
    assign w_page     = r_page[w_rd];
    assign w_dirty    = r_dirty[w_rd];
    assign w_pins     = r_pins[w_rd];
    assign w_older    = r_older[w_rd];
    assign w_newer    = r_newer[w_rd];
    assign w_cur_nil  = (r_cur == NIL);
    assign w_f_l      = LW'(r_f);
    assign w_can_emit = !r_emit || !i_out_full;
    assign w_rel_ok   = (32'(i_cmd.frame_index) < NUM_FRAMES)
                        && r_res[FW'(i_cmd.frame_index)];
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && w_can_emit;
    assign o_emit     = r_emit;
    assign o_res      = r_out;

    // Clamp pool size writes into 1..NUM_FRAMES
    always_comb begin
        priority if (i_cfg_wdata == 5'd0) begin
            w_cfg_v = LW'(1);
        end else if (32'(i_cfg_wdata) > NUM_FRAMES) begin
            w_cfg_v = NIL;
        end else begin
            w_cfg_v = LW'(i_cfg_wdata);
        end
    end

    // Main engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_tab[i]   <= 8'd0;
                r_page[i]  <= 32'd0;
                r_dirty[i] <= 1'b0;
                r_pins[i]  <= 8'd0;
                r_older[i] <= NIL;
                r_newer[i] <= NIL;
                r_res[i]   <= 1'b0;
                r_fstk[i]  <= FW'(i);
            end
            r_newest <= NIL;
            r_oldest <= NIL;
            r_used   <= '0;
            r_ftop   <= '0;
            r_pool   <= POOL_RST;
            r_state  <= S_IDLE;
            r_emit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool <= w_cfg_v;
            end
            if (r_emit && !i_out_full) begin
                r_emit <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            K_REQ: begin
                                r_cur   <= r_newest;
                                r_state <= S_LOOK;
                            end
                            K_REL: begin
                                if (w_rel_ok) begin
                                    r_f      <= FW'(i_cmd.frame_index);
                                    r_move   <= M_REL;
                                    r_inlist <= 1'b1;
                                    r_state  <= S_MOVE;
                                end else begin
                                    r_emit <= 1'b1;
                                    r_out  <= '{ST_OK, 1'b0, i_cmd.frame_index,
                                                1'b0, 8'd0, 32'd0, 1'b1};
                                end
                            end
                            K_CLOSE: begin
                                r_cur   <= r_oldest;
                                r_state <= S_CWALK;
                            end
                            default: begin
                                r_emit <= 1'b1;
                                r_out  <= '{ST_OK, 1'b0, 4'd0, 1'b0, 8'd0, 32'd0, 1'b1};
                            end
                        endcase
                    end
                end
                // Walk newest to oldest for a tag match
                S_LOOK: begin
                    priority if (w_cur_nil) begin
                        r_state <= S_MISS;
                    end else if (w_tab == r_cmd.tbl_id && w_page == r_cmd.page_number) begin
                        r_f      <= FW'(r_cur);
                        r_move   <= M_HIT;
                        r_inlist <= 1'b1;
                        r_state  <= S_MOVE;
                    end else begin
                        r_cur <= w_older;
                    end
                end
                // Free frame if the pool has room, else victim search
                S_MISS: begin
                    if (r_used < r_pool && r_ftop < NIL) begin
                        r_f      <= r_fstk[FW'(r_ftop)];
                        r_ftop   <= r_ftop + LW'(1);
                        r_used   <= r_used + LW'(1);
                        r_move   <= M_LOAD;
                        r_inlist <= 1'b0;
                        r_wbv    <= 1'b0;
                        r_wbt    <= 8'd0;
                        r_wbp    <= 32'd0;
                        r_state  <= S_MOVE;
                    end else begin
                        r_cur   <= r_oldest;
                        r_state <= S_VICT;
                    end
                end
                // Oldest unpinned frame
                S_VICT: begin
                    priority if (w_cur_nil) begin
                        if (w_can_emit) begin
                            r_emit  <= 1'b1;
                            r_out   <= '{ST_NO_FRAME, 1'b0, 4'd0, 1'b0, 8'd0, 32'd0, 1'b1};
                            r_state <= S_IDLE;
                        end
                    end else if (w_pins != 8'd0) begin
                        r_cur <= w_newer;
                    end else begin
                        r_f      <= FW'(r_cur);
                        r_wbv    <= w_dirty;
                        r_wbt    <= w_dirty ? w_tab : 8'd0;
                        r_wbp    <= w_dirty ? w_page : 32'd0;
                        r_move   <= M_LOAD;
                        r_inlist <= 1'b1;
                        r_state  <= S_MOVE;
                    end
                end
                // Make frame most recent, update it, report
                S_MOVE: begin
                    if (w_can_emit) begin
                        if (r_inlist) begin
                            if (w_f_l != r_newest) begin
                                if (w_older != NIL) begin
                                    r_newer[FW'(w_older)] <= w_newer;
                                end else begin
                                    r_oldest <= w_newer;
                                end
                                r_older[FW'(w_newer)]  <= w_older;
                                r_older[r_f]           <= r_newest;
                                r_newer[r_f]           <= NIL;
                                r_newer[FW'(r_newest)] <= w_f_l;
                                r_newest               <= w_f_l;
                            end
                        end else begin
                            r_older[r_f] <= r_newest;
                            r_newer[r_f] <= NIL;
                            if (r_newest != NIL) begin
                                r_newer[FW'(r_newest)] <= w_f_l;
                            end else begin
                                r_oldest <= w_f_l;
                            end
                            r_newest <= w_f_l;
                        end
                        r_emit  <= 1'b1;
                        r_state <= S_IDLE;
                        unique case (r_move)
                            M_HIT: begin
                                if (w_pins != 8'hFF) begin
                                    r_pins[r_f] <= w_pins + 8'd1;
                                end
                                r_out <= '{ST_OK, 1'b1, 4'(r_f), 1'b0, 8'd0, 32'd0, 1'b1};
                            end
                            M_LOAD: begin
                                r_tab[r_f]   <= r_cmd.tbl_id;
                                r_page[r_f]  <= r_cmd.page_number;
                                r_dirty[r_f] <= 1'b0;
                                r_pins[r_f]  <= 8'd1;
                                r_res[r_f]   <= 1'b1;
                                r_out <= '{ST_OK, 1'b0, 4'(r_f), r_wbv, r_wbt, r_wbp, 1'b1};
                            end
                            default: begin
                                if (w_pins != 8'd0) begin
                                    r_pins[r_f] <= w_pins - 8'd1;
                                end
                                if (r_cmd.set_dirty) begin
                                    r_dirty[r_f] <= 1'b1;
                                end
                                r_out <= '{ST_OK, 1'b0, r_cmd.frame_index, 1'b0, 8'd0,
                                           32'd0, 1'b1};
                            end
                        endcase
                    end
                end
                // Close: evict the table's frames oldest first, stopping at a pinned one
                default: begin
                    if (w_can_emit) begin
                        priority if (w_cur_nil) begin
                            r_emit  <= 1'b1;
                            r_out   <= '{ST_OK, 1'b0, 4'd0, 1'b0, 8'd0, 32'd0, 1'b1};
                            r_state <= S_IDLE;
                        end else if (w_tab == r_cmd.tbl_id) begin
                            if (w_pins != 8'd0) begin
                                r_emit  <= 1'b1;
                                r_out   <= '{ST_CLOSE_BLOCKED, 1'b0, 4'd0, 1'b0, 8'd0,
                                             32'd0, 1'b1};
                                r_state <= S_IDLE;
                            end else begin
                                if (w_dirty) begin
                                    r_emit <= 1'b1;
                                    r_out  <= '{ST_OK, 1'b0, 4'd0, 1'b1, w_tab, w_page, 1'b0};
                                end
                                if (w_older != NIL) begin
                                    r_newer[FW'(w_older)] <= w_newer;
                                end else begin
                                    r_oldest <= w_newer;
                                end
                                if (w_newer != NIL) begin
                                    r_older[FW'(w_newer)] <= w_older;
                                end else begin
                                    r_newest <= w_older;
                                end
                                r_older[w_rd] <= NIL;
                                r_newer[w_rd] <= NIL;
                                r_tab[w_rd]   <= 8'd0;
                                r_page[w_rd]  <= 32'd0;
                                r_dirty[w_rd] <= 1'b0;
                                r_res[w_rd]   <= 1'b0;
                                if (r_ftop != '0) begin
                                    r_ftop                   <= r_ftop - LW'(1);
                                    r_fstk[FW'(r_ftop - LW'(1))] <= w_rd;
                                end
                                if (r_used != '0) begin
                                    r_used <= r_used - LW'(1);
                                end
                                r_cur <= w_newer;
                            end
                        end else begin
                            r_cur <= w_newer;
                        end
                    end
                end
            endcase
        end
    end

    // Frames taken from the free stack always match frames in use
    a_ftop_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ftop == r_used) else $error("free stack top and use count disagree");

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NIL) else $error("use count above frame count");

    a_ends_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_newest == NIL) == (r_oldest == NIL)) else $error("recency list ends disagree");

    a_pool_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool != '0 && r_pool <= NIL) else $error("pool size out of range");

endmodule

// File: rtl/core/lru_pinned_page_buffer_pool_core.sv
// From item accept to result: an undefined item or a release of a frame not in use is
// answered from idle; other releases go through the move step. A request walks the
// tags, then takes a free frame or walks for a victim, one frame per cycle.
// A close walks oldest first, one frame per cycle while the result queue has room.
// One item in the engine at a time; 2-entry queues on both sides.
// Reset (synchronous, active low) empties the pool, frees all frames, pool size min(16, NUM_FRAMES).
module lru_pinned_page_buffer_pool_core #(
    parameter int NUM_FRAMES = lpp_pkg::NUM_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lpp_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output lpp_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata
);
    import lpp_pkg::*;

    logic      w_cmd_valid;
    t_cmd      w_cmd;
    logic      w_cmd_take;
    logic      w_emit;
    t_out_item w_res;
    logic      w_out_full;

    lpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    lpp_back #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_emit      (w_emit),
        .o_res       (w_res),
        .i_out_full  (w_out_full)
    );

    lpp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_emit),
        .i_res    (w_res),
        .o_full   (w_out_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
